// ===== rtl/i2cme_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps

package i2cme_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_STOP_A    = 4'd3,
    PH_STOP_B    = 4'd4,
    PH_STOP_C    = 4'd5,
    PH_WR_SETUP  = 4'd6,
    PH_WR_HIGH   = 4'd7,
    PH_ACK_SETUP = 4'd8,
    PH_ACK_HIGH  = 4'd9,
    PH_ACK_LOW   = 4'd10,
    PH_RD_HIGH   = 4'd11,
    PH_RD_LOW    = 4'd12
  } phase_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       nack;
  } out_item_t;

  // One classified tick as it travels from the front stage to the engine.
  typedef struct packed {
    logic       cmd_valid;
    opcode_e    opcode;
    logic [7:0] wbyte;
    logic       sda;
  } tick_t;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
  localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
  localparam int unsigned QUEUE_DEPTH       = 4;

endpackage

// ===== rtl/i2cme_front.sv =====
// Input stage: registers each accepted tick and classifies its opcode.
// Depends on i2cme_pkg.
`timescale 1ns / 1ps

module i2cme_front
  import i2cme_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_ready_o,
  output logic     tick_valid_o,
  output tick_t    tick_o,
  input  logic     tick_ready_i
);

  logic  full_q, full_d;
  tick_t tick_q, tick_d;
  logic  take;

  assign take       = in_valid_i && in_ready_o;
  assign in_ready_o = !full_q || tick_ready_i;

  always_comb begin
    full_d = full_q;
    tick_d = tick_q;
    if (in_ready_o) begin
      full_d = in_valid_i;
    end
    if (take) begin
      tick_d.cmd_valid = in_item_i.cmd_valid;
      tick_d.wbyte     = in_item_i.write_byte;
      tick_d.sda       = in_item_i.sda_in;
      // Every two-bit value is a defined opcode, so the cast covers all inputs.
      tick_d.opcode    = opcode_e'(in_item_i.opcode);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q <= tick_d;
  end

  assign tick_valid_o = full_q;
  assign tick_o       = tick_q;

endmodule

// ===== rtl/i2cme_queue.sv =====
// Small FIFO of classified ticks between the front stage and the engine.
// Depends on i2cme_pkg.
`timescale 1ns / 1ps

module i2cme_queue
  import i2cme_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  tick_t push_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output tick_t pop_o,
  input  logic  pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  tick_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntOne;
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

// ===== rtl/i2cme_back.sv =====
// Bus sequencer: steps the I2C phase machine once per tick and registers the result.
// Depends on i2cme_pkg.
`timescale 1ns / 1ps

module i2cme_back
  import i2cme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  input  logic        tick_valid_i,
  input  tick_t       tick_i,
  output logic        tick_ready_o,
  output logic        out_valid_o,
  output out_item_t   out_item_o,
  input  logic        out_ready_i
);

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [15:0] delay_q, delay_d;
  logic [15:0] half_q;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  rd_byte_q, rd_byte_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drv_q, drv_d;
  logic        nack_q, nack_d;
  logic        done_d;
  logic        out_valid_q;
  out_item_t   out_item_q, res;
  logic        pop;

  logic [15:0] delay_dec;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_shl;
  logic        arm, finish;

  assign tick_ready_o = !out_valid_q || out_ready_i;
  assign pop          = tick_valid_i && tick_ready_o;

  // Next-state logic for one tick.
  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    delay_d   = delay_q;
    shift_d   = shift_q;
    rd_byte_d = rd_byte_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    drv_d     = drv_q;
    nack_d    = nack_q;
    done_d    = 1'b0;
    arm       = 1'b0;
    finish    = 1'b0;
    delay_dec = delay_q - {15'd0, (delay_q != 16'd0)};
    bit_inc   = bit_cnt_q + 4'd1;
    shift_shl = {shift_q[6:0], 1'b0};

    if (pop) begin
      if (phase_q == PH_IDLE) begin
        if (tick_i.cmd_valid) begin
          bit_cnt_d = 4'd0;
          arm       = 1'b1;
          case (tick_i.opcode)
            OP_START: begin
              drv_d   = 1'b1;
              scl_d   = 1'b1;
              sda_d   = 1'b1;
              phase_d = PH_START_A;
            end
            OP_STOP: begin
              drv_d   = 1'b1;
              sda_d   = 1'b0;
              phase_d = PH_STOP_A;
            end
            OP_WRITE: begin
              shift_d = tick_i.wbyte;
              drv_d   = 1'b1;
              sda_d   = tick_i.wbyte[7];
              phase_d = PH_WR_SETUP;
            end
            default: begin
              shift_d = 8'd0;
              drv_d   = 1'b0;
              scl_d   = 1'b1;
              phase_d = PH_RD_HIGH;
            end
          endcase
        end
      end else begin
        delay_d = delay_dec;
        if (delay_dec == 16'd0) begin
          arm = 1'b1;
          case (phase_q)
            PH_START_A: begin
              sda_d   = 1'b0;
              phase_d = PH_START_B;
            end
            PH_START_B: begin
              scl_d  = 1'b0;
              finish = 1'b1;
            end
            PH_STOP_A: begin
              scl_d   = 1'b1;
              phase_d = PH_STOP_B;
            end
            PH_STOP_B: begin
              sda_d   = 1'b1;
              phase_d = PH_STOP_C;
            end
            PH_WR_SETUP: begin
              scl_d   = 1'b1;
              phase_d = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
              scl_d     = 1'b0;
              bit_cnt_d = bit_inc;
              shift_d   = shift_shl;
              if (bit_inc < BITS_PER_BYTE) begin
                drv_d   = 1'b1;
                sda_d   = shift_shl[7];
                phase_d = PH_WR_SETUP;
              end else begin
                drv_d   = 1'b0;
                phase_d = PH_ACK_SETUP;
              end
            end
            PH_ACK_SETUP: begin
              scl_d   = 1'b1;
              phase_d = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
              nack_d  = tick_i.sda;
              scl_d   = 1'b0;
              phase_d = PH_ACK_LOW;
            end
            PH_ACK_LOW: begin
              drv_d  = 1'b1;
              finish = 1'b1;
            end
            PH_RD_HIGH: begin
              shift_d   = {shift_q[6:0], tick_i.sda};
              bit_cnt_d = bit_inc;
              scl_d     = 1'b0;
              phase_d   = PH_RD_LOW;
            end
            PH_RD_LOW: begin
              if (bit_cnt_q < BITS_PER_BYTE) begin
                scl_d   = 1'b1;
                phase_d = PH_RD_HIGH;
              end else begin
                drv_d     = 1'b1;
                rd_byte_d = shift_q;
                finish    = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      if (finish) begin
        phase_d = PH_IDLE;
        delay_d = 16'd0;
        done_d  = 1'b1;
      end else if (arm) begin
        delay_d = half_q;
      end
    end
  end

  // Result of a tick shows the line state after that tick.
  always_comb begin
    res.scl_out   = scl_d;
    res.sda_out   = drv_d ? sda_d : 1'b1;
    res.sda_drive = drv_d;
    res.busy_res  = (phase_d != PH_IDLE);
    res.done_res  = done_d;
    res.read_byte = rd_byte_d;
    res.nack      = nack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= 4'd0;
      delay_q     <= 16'd0;
      half_q      <= HALF_PERIOD_RESET;
      shift_q     <= 8'd0;
      rd_byte_q   <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      nack_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      delay_q   <= delay_d;
      shift_q   <= shift_d;
      rd_byte_q <= rd_byte_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      drv_q     <= drv_d;
      nack_q    <= nack_d;
      // A zero half period behaves as one tick.
      if (cfg_valid_i) begin
        half_q <= (cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i;
      end
      if (tick_ready_o) begin
        out_valid_q <= tick_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/i2c_master_byte_engine.sv =====
// Path: an accepted tick passes through the front register, the tick queue and
// the engine output register before its result leaves.
// Throughput: one tick per cycle while the output is not stalled, set by the phase step in the engine.
// Reset (asynchronous, active low) idles the bus with SCL and SDA driven high,
// empties the pipeline and loads a half period of 250 ticks.
// Top level; depends on i2cme_pkg, i2cme_front, i2cme_queue and i2cme_back.
`timescale 1ns / 1ps

module i2c_master_byte_engine
  import i2cme_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_item_t    in_item_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output out_item_t   out_item_o,
  input  logic        out_ready_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output logic        cfg_ready_o
);

  logic  f_valid, f_ready;
  tick_t f_tick;
  logic  q_valid, q_ready;
  tick_t q_tick;

  assign cfg_ready_o = 1'b1;

  i2cme_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_ready_o  (in_ready_o),
    .tick_valid_o(f_valid),
    .tick_o      (f_tick),
    .tick_ready_i(f_ready)
  );

  i2cme_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_i      (f_tick),
    .push_ready_o(f_ready),
    .pop_valid_o (q_valid),
    .pop_o       (q_tick),
    .pop_ready_i (q_ready)
  );

  i2cme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .tick_valid_i(q_valid),
    .tick_i      (q_tick),
    .tick_ready_o(q_ready),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_ready_i (out_ready_i)
  );

endmodule
